>>> hw/rtl/csa_pkg.sv
// shared types and constants of the count sketch accumulator
package csa_pkg;

    // opcodes of an input transaction
    localparam logic [1:0] OP_ACCUM      = 2'd0;
    localparam logic [1:0] OP_READ       = 2'd1;
    localparam logic [1:0] OP_READ_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BUCKETS = 2'd0;
    localparam logic [1:0] REG_VEC_LEN = 2'd1;

    // field and register widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int BKT_CFG_W   = 9;
    localparam int VEC_CFG_W   = 7;
    localparam int ACC_W       = 48;

    // register reset values
    localparam logic [BKT_CFG_W-1:0] BKT_CFG_RESET = 9'd256;
    localparam logic [VEC_CFG_W-1:0] VEC_CFG_RESET = 7'd64;

    // saturation limits of the accumulator
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // input transaction
    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         bucket;
        logic [5:0]         row;
        logic               negate;
        logic signed [31:0] entry_value;
    } csa_in_t;

    // result transaction
    typedef struct packed {
        logic                    status;
        logic signed [ACC_W-1:0] sum_value;
    } csa_out_t;

    // classified operation passed from front to back
    typedef struct packed {
        logic [1:0]         opcode;
        logic               negate;
        logic signed [31:0] entry_value;
        logic               oor;
    } csa_op_t;

    // back end status seen by the top level
    typedef struct packed {
        logic clr_busy;
        logic s1_valid;
    } csa_back_status_t;

endpackage

>>> hw/rtl/csa_ram.sv
// generic simple dual port ram with registered read
module csa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, old data on a same address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/csa_front.sv
// front end: configuration registers, range check and address calculation
module csa_front
    import csa_pkg::*;
#(
    parameter int BUCKETS    = 256,
    parameter int VECTOR_LEN = 64,
    parameter int AW         = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  csa_in_t                in_data,
    output csa_op_t                op,
    output logic [AW-1:0]          addr
);

    logic [BKT_CFG_W-1:0] bkt_cfg_reg;
    logic [VEC_CFG_W-1:0] vec_cfg_reg;
    logic                 bkt_ok;
    logic                 row_ok;
    logic [31:0]          addr_full;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkt_cfg_reg <= BKT_CFG_RESET;
            vec_cfg_reg <= VEC_CFG_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_BUCKETS: bkt_cfg_reg <= cfg_data[BKT_CFG_W-1:0];
                REG_VEC_LEN: vec_cfg_reg <= cfg_data[VEC_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // range check against both register and store size
    always_comb
    begin
        bkt_ok = ({1'b0, in_data.bucket} < bkt_cfg_reg)
              && (32'(in_data.bucket) < 32'(BUCKETS));
        row_ok = ({1'b0, in_data.row} < vec_cfg_reg)
              && (32'(in_data.row) < 32'(VECTOR_LEN));
    end

    // entry address is bucket-major
    assign addr_full = 32'(in_data.bucket) * 32'(VECTOR_LEN) + 32'(in_data.row);
    assign addr      = addr_full[AW-1:0];

    // classified operation
    always_comb
    begin
        op.opcode      = in_data.opcode;
        op.negate      = in_data.negate;
        op.entry_value = in_data.entry_value;
        op.oor         = !(bkt_ok && row_ok);
    end

endmodule

>>> hw/rtl/csa_queue.sv
// short register fifo between front and back end
module csa_queue #(
    parameter int W     = 50,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers wrap at the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/csa_back.sv
// back end: store clearing, read-modify-write with forwarding, result register
module csa_back
    import csa_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  csa_op_t          q_op,
    input  logic [AW-1:0]    q_addr,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output csa_out_t         out_data,
    output csa_back_status_t status
);

    logic                    clr_busy_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic                    s1_valid_reg;
    csa_op_t                 s1_op_reg;
    logic [AW-1:0]           s1_addr_reg;
    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic [ACC_W-1:0]        fwd_data_reg;
    logic                    out_valid_reg;
    csa_out_t                out_data_reg;

    logic                    out_take;
    logic                    s1_free;
    logic [ACC_W-1:0]        rd_data;
    logic signed [ACC_W-1:0] cur;
    logic signed [ACC_W:0]   cur_x;
    logic signed [ACC_W:0]   val_x;
    logic signed [ACC_W:0]   sum_x;
    logic signed [ACC_W-1:0] sat_sum;
    logic signed [ACC_W-1:0] result;
    logic                    item_we;
    logic [ACC_W-1:0]        item_wdata;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [ACC_W-1:0]        ram_wdata;

    // handshake between stages
    assign out_take = !out_valid_reg || out_ready;
    assign s1_free  = !s1_valid_reg || out_take;
    assign q_pop    = !q_empty && s1_free && !clr_busy_reg;

    // store
    csa_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_addr),
        .rdata (rd_data)
    );

    // forward the last write, the read issued alongside it saw old data
    assign cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;

    // widened add or subtract with saturation
    always_comb
    begin
        cur_x = {cur[ACC_W-1], cur};
        val_x = {{(ACC_W + 1 - 32){s1_op_reg.entry_value[31]}}, s1_op_reg.entry_value};
        sum_x = s1_op_reg.negate ? (cur_x - val_x) : (cur_x + val_x);
        if (sum_x[ACC_W] != sum_x[ACC_W-1])
        begin
            sat_sum = sum_x[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sat_sum = sum_x[ACC_W-1:0];
        end
    end

    // per opcode result and store update
    always_comb
    begin
        result     = cur;
        item_we    = 1'b0;
        item_wdata = '0;
        case (s1_op_reg.opcode)
            OP_ACCUM:
            begin
                result     = sat_sum;
                item_we    = 1'b1;
                item_wdata = sat_sum;
            end
            OP_READ_CLEAR:
            begin
                item_we    = 1'b1;
                item_wdata = '0;
            end
            default:
            begin
                item_we = 1'b0;
            end
        endcase
        item_we = item_we && s1_valid_reg && out_take && !s1_op_reg.oor;
    end

    // write port shared with the clearing pass
    assign ram_we    = clr_busy_reg || item_we;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_busy_reg ? '0 : item_wdata;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (s1_free)
            begin
                s1_valid_reg <= q_pop;
            end
            if (item_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_op_reg   <= q_op;
            s1_addr_reg <= q_addr;
        end
        if (item_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= item_wdata;
        end
        if (out_take && s1_valid_reg)
        begin
            out_data_reg.status    <= s1_op_reg.oor;
            out_data_reg.sum_value <= s1_op_reg.oor ? '0 : result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.clr_busy = clr_busy_reg;
    assign status.s1_valid = s1_valid_reg;

endmodule

>>> hw/rtl/countsketch_accumulator_unit.sv
// count sketch accumulator top level
//
// Input channel in_valid/in_ready/in_data carries one operation per transaction:
// accumulate +/- entry_value into the entry at (bucket, row), read the entry, or
// read it and clear it. Each input transaction gives exactly one result transaction
// on out_valid/out_ready/out_data, in order; status 1 marks a bucket or row outside
// the configured sizes, with sum_value 0 and the store untouched.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data while idle.
// A front end range-checks and forms the address, a four entry queue decouples it
// from the back end, which does a read-modify-write on a single store memory.
// Each operation is registered in the queue, the operation stage and the result
// register; throughput is one transaction per cycle while the receiver does not
// stall, also for repeated hits on one entry, since the last write is forwarded
// past the registered read of the store. After reset the store is zeroed by a
// pass over all BUCKETS*VECTOR_LEN entries (16384 with the defaults), in_ready low.
// When the receiver stalls the result register holds, the back end stops, and the
// queue absorbs up to four more inputs before in_ready drops.
module countsketch_accumulator_unit
    import csa_pkg::*;
#(
    parameter int BUCKETS    = 256,
    parameter int VECTOR_LEN = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  csa_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output csa_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = BUCKETS * VECTOR_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = AW + $bits(csa_op_t);

    csa_op_t          fe_op;
    logic [AW-1:0]    fe_addr;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [QW-1:0]    q_rd_data;
    csa_op_t          q_op;
    logic [AW-1:0]    q_addr;
    csa_back_status_t be_status;
    logic             in_push;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full && !be_status.clr_busy;
    assign in_push   = in_valid && in_ready;

    // classification
    csa_front #(
        .BUCKETS    (BUCKETS),
        .VECTOR_LEN (VECTOR_LEN),
        .AW         (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .op        (fe_op),
        .addr      (fe_addr)
    );

    // decoupling queue
    csa_queue #(
        .W     (QW),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_push),
        .push_data ({fe_addr, fe_op}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .empty     (q_empty)
    );

    assign q_addr = q_rd_data[QW-1 -: AW];
    assign q_op   = q_rd_data[$bits(csa_op_t)-1:0];

    // execution
    csa_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_op      (q_op),
        .q_addr    (q_addr),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .status    (be_status)
    );

    // no transaction enters while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        be_status.clr_busy |-> !in_ready)
        else $error("input accepted during store clearing");

    // the back end holds nothing while the clearing pass owns the write port
    a_back_idle_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        be_status.clr_busy |-> !be_status.s1_valid && !out_valid)
        else $error("back end busy during store clearing");

    // an out of range result carries a zero sum
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status) |-> (out_data.sum_value == '0))
        else $error("out of range result with nonzero sum");

    // a rising result needs an operation in flight in the cycle before
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(be_status.s1_valid))
        else $error("result without an operation in flight");

endmodule
